[rtl/readout_zero_reference_tracker_top_macros.svh]
// Assertion macros for the readout zero reference tracker.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef READOUT_ZERO_REFERENCE_TRACKER_TOP_MACROS_SVH
`define READOUT_ZERO_REFERENCE_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RZRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RZRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rzrt_pkg.sv]
// Shared constants for the readout zero reference tracker.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package rzrt_pkg;

  localparam int DEF_SETPOINTS          = 4;
  localparam int DEF_RADIAL_BUTTON_BASE = 0;
  localparam int DEF_AXIAL_BUTTON_BASE  = 4;
  localparam int DEF_TOGGLE_BUTTON_BIT  = 8;

  localparam int POS_W  = 32;
  localparam int BTN_W  = 16;
  localparam int REQ_W  = 3;
  localparam int SLOT_W = 3;

  localparam logic [REQ_W-1:0] REQ_UPDATE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_BUTTONS  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ZERO_MAIN = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET_RMAIN = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ZERO_SLOT = 3'd4;

  localparam logic AX_AXIAL  = 1'b0;
  localparam logic AX_RADIAL = 1'b1;

endpackage

[rtl/rzrt_if.sv]
// Valid/ready channel interfaces for request and result words.
// Depends on rzrt_pkg for field widths.
`timescale 1ns / 1ps

interface rzrt_in_if;
  import rzrt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [POS_W-1:0]  position;
  logic [BTN_W-1:0]         buttons;
  logic                     axis_sel;
  logic [SLOT_W-1:0]        slot;

  modport source (output valid, req_type, position, buttons, axis_sel, slot, input ready);
  modport sink (input valid, req_type, position, buttons, axis_sel, slot, output ready);
endinterface

interface rzrt_out_if;
  import rzrt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  delta_out;
  logic signed [POS_W-1:0]  ref_out;
  logic                     slot_active;
  logic                     radius_disp;

  modport source (output valid, delta_out, ref_out, slot_active, radius_disp, input ready);
  modport sink (input valid, delta_out, ref_out, slot_active, radius_disp, output ready);
endinterface

[rtl/readout_zero_reference_tracker_top.sv]
// Two-axis readout zero reference tracker. One request word is taken at a time and one
// result word comes back for it, reporting the addressed axis and slot after the update.
// All arithmetic goes through a single 32-bit add/subtract unit that a small sequencer
// walks over the main zero and the setpoint slots of the addressed axis (both axes for a
// position update or a button word), one slot per cycle but for a zero main, which visits
// each slot twice, to shift its reference and then to refresh its delta. A zero slot whose
// slot is zero or above SETPOINTS, and an unused request code, skip the walk. The final state
// waits while the previous result word is still unclaimed. The request side is ready
// again once the result is in the output register, which holds it until the sink takes it.
// Depends on rzrt_pkg, rzrt_if and the assertion macro header.
`timescale 1ns / 1ps
`include "readout_zero_reference_tracker_top_macros.svh"

module readout_zero_reference_tracker_top #(
  parameter int SETPOINTS          = rzrt_pkg::DEF_SETPOINTS,
  parameter int RADIAL_BUTTON_BASE = rzrt_pkg::DEF_RADIAL_BUTTON_BASE,
  parameter int AXIAL_BUTTON_BASE  = rzrt_pkg::DEF_AXIAL_BUTTON_BASE,
  parameter int TOGGLE_BUTTON_BIT  = rzrt_pkg::DEF_TOGGLE_BUTTON_BIT
) (
  input  logic        clk,
  input  logic        rst,
  rzrt_in_if.sink     in_ch,
  rzrt_out_if.source  out_ch
);
  import rzrt_pkg::*;

  localparam int IW = (SETPOINTS > 1) ? $clog2(SETPOINTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CUR, ST_MAIN, ST_SLOT_A, ST_SLOT_B, ST_FIN
  } st_t;

  st_t st;

  logic [POS_W-1:0]  main_ref   [2];
  logic [POS_W-1:0]  main_delta [2];
  logic [POS_W-1:0]  slot_ref   [2][SETPOINTS];
  logic [POS_W-1:0]  slot_delta [2][SETPOINTS];
  logic              slot_valid [2][SETPOINTS];
  logic [POS_W-1:0]  axial_raw;
  logic [BTN_W-1:0]  last_buttons;
  logic              radius_flag;

  // Latched request and working registers.
  logic [REQ_W-1:0]  req_q;
  logic              axis_q;
  logic [SLOT_W-1:0] slot_q;
  logic [BTN_W-1:0]  rise;
  logic [POS_W-1:0]  cur;
  logic [POS_W-1:0]  shift;
  logic              ax;
  logic [IW-1:0]     idx;

  logic              out_valid;
  logic [POS_W-1:0]  out_delta;
  logic [POS_W-1:0]  out_ref;
  logic              out_active;
  logic              out_radius;

  // Single read port over the slot stores.
  logic              rd_ax;
  logic [IW-1:0]     rd_idx;
  logic [POS_W-1:0]  sref_rd;
  logic [POS_W-1:0]  sdelta_rd;
  logic              svalid_rd;

  logic [POS_W-1:0]  add_a;
  logic [POS_W-1:0]  add_b;
  logic              add_sub;
  logic [POS_W-1:0]  sum;

  logic [4:0]        bpos;
  logic              hit;
  logic              last_idx;
  logic              slot_ok;
  logic              two_axes;
  st_t               slot_st;

  always_comb begin
    rd_ax     = (st == ST_FIN) ? axis_q : ax;
    rd_idx    = (st == ST_FIN) ? IW'(slot_q - 3'd1) : idx;
    sref_rd   = slot_ref[rd_ax][rd_idx];
    sdelta_rd = slot_delta[rd_ax][rd_idx];
    svalid_rd = slot_valid[rd_ax][rd_idx];
  end

  // The shared add/subtract unit.
  always_comb begin
    case (st)
      ST_CUR: begin
        add_a   = main_ref[rd_ax];
        add_b   = main_delta[rd_ax];
        add_sub = 1'b0;
      end
      ST_MAIN: begin
        add_a   = cur;
        add_b   = main_ref[rd_ax];
        add_sub = 1'b1;
      end
      ST_SLOT_A: begin
        add_a   = sref_rd;
        add_b   = shift;
        add_sub = 1'b0;
      end
      default: begin
        add_a   = cur;
        add_b   = sref_rd;
        add_sub = 1'b1;
      end
    endcase
    sum = add_a + (add_b ^ {POS_W{add_sub}}) + POS_W'(add_sub);
  end

  always_comb begin
    bpos = ((ax == AX_RADIAL) ? 5'(RADIAL_BUTTON_BASE) : 5'(AXIAL_BUTTON_BASE)) + 5'(idx);
    if (req_q == REQ_BUTTONS) begin
      hit = (bpos < 5'd16) && rise[bpos[3:0]];
    end else begin
      hit = (32'(idx) + 32'd1 == 32'(slot_q));
    end
    last_idx = (idx == IW'(SETPOINTS - 1));
    slot_ok  = (32'(slot_q) <= SETPOINTS);
    two_axes = (req_q == REQ_UPDATE) || (req_q == REQ_BUTTONS);
    slot_st  = (req_q == REQ_ZERO_MAIN || req_q == REQ_SET_RMAIN) ? ST_SLOT_A : ST_SLOT_B;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      axial_raw    <= '0;
      last_buttons <= '0;
      radius_flag  <= 1'b1;
      out_valid    <= 1'b0;
      ax           <= AX_AXIAL;
      idx          <= '0;
      for (int a = 0; a < 2; a++) begin
        main_ref[a]   <= '0;
        main_delta[a] <= '0;
        for (int i = 0; i < SETPOINTS; i++) begin
          slot_ref[a][i]   <= '0;
          slot_delta[a][i] <= '0;
          slot_valid[a][i] <= 1'b0;
        end
      end
    end else begin
      // In the final state the result register is reloaded below instead.
      if (out_valid && out_ch.ready && st != ST_FIN) begin
        out_valid <= 1'b0;
      end

      case (st)
        ST_IDLE: begin
          if (in_ch.valid) begin
            req_q  <= in_ch.req_type;
            axis_q <= in_ch.axis_sel;
            slot_q <= in_ch.slot;
            idx    <= '0;
            case (in_ch.req_type)
              REQ_UPDATE: begin
                axial_raw <= in_ch.position;
                ax        <= AX_AXIAL;
                st        <= ST_CUR;
              end
              REQ_BUTTONS: begin
                rise         <= in_ch.buttons & ~last_buttons;
                last_buttons <= in_ch.buttons;
                if (in_ch.buttons[4'(TOGGLE_BUTTON_BIT)] && !last_buttons[4'(TOGGLE_BUTTON_BIT)]) begin
                  radius_flag <= !radius_flag;
                end
                ax <= AX_AXIAL;
                st <= ST_CUR;
              end
              REQ_ZERO_MAIN: begin
                ax <= in_ch.axis_sel;
                st <= ST_CUR;
              end
              REQ_SET_RMAIN: begin
                ax  <= AX_RADIAL;
                cur <= in_ch.position;
                st  <= ST_MAIN;
              end
              REQ_ZERO_SLOT: begin
                ax <= in_ch.axis_sel;
                if (in_ch.slot != '0 && 32'(in_ch.slot) <= SETPOINTS) begin
                  st <= ST_CUR;
                end else begin
                  st <= ST_FIN;
                end
              end
              default: begin
                st <= ST_FIN;
              end
            endcase
          end
        end

        ST_CUR: begin
          // The radial position is never measured: it is main reference plus main delta.
          cur <= (ax == AX_RADIAL) ? sum : axial_raw;
          if (req_q == REQ_UPDATE || req_q == REQ_ZERO_MAIN) begin
            st <= ST_MAIN;
          end else begin
            st <= ST_SLOT_B;
          end
        end

        ST_MAIN: begin
          if (req_q == REQ_UPDATE) begin
            main_delta[ax] <= sum;
            st             <= ST_SLOT_B;
          end else begin
            shift          <= sum;
            main_ref[ax]   <= cur;
            main_delta[ax] <= '0;
            st             <= ST_SLOT_A;
          end
        end

        ST_SLOT_A, ST_SLOT_B: begin
          if (st == ST_SLOT_A) begin
            if (svalid_rd) begin
              slot_ref[ax][idx] <= sum;
            end
          end else if (req_q == REQ_UPDATE || req_q == REQ_ZERO_MAIN) begin
            if (svalid_rd) begin
              slot_delta[ax][idx] <= sum;
            end
          end else if (hit) begin
            slot_ref[ax][idx]   <= cur;
            slot_delta[ax][idx] <= '0;
            slot_valid[ax][idx] <= 1'b1;
          end

          // A zero main revisits the same slot to refresh its delta after the shift.
          if (st == ST_SLOT_A && req_q == REQ_ZERO_MAIN) begin
            st <= ST_SLOT_B;
          end else if (!last_idx) begin
            idx <= idx + 1'b1;
            st  <= slot_st;
          end else if (two_axes && ax == AX_AXIAL) begin
            ax  <= AX_RADIAL;
            idx <= '0;
            st  <= ST_CUR;
          end else begin
            st <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_radius <= radius_flag;
            if (slot_q == '0) begin
              out_delta  <= main_delta[rd_ax];
              out_ref    <= main_ref[rd_ax];
              out_active <= 1'b1;
            end else if (slot_ok) begin
              out_delta  <= sdelta_rd;
              out_ref    <= sref_rd;
              out_active <= svalid_rd;
            end else begin
              out_delta  <= '0;
              out_ref    <= '0;
              out_active <= 1'b0;
            end
            st <= ST_IDLE;
          end
        end

        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (st == ST_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.delta_out   = out_delta;
  assign out_ch.ref_out     = out_ref;
  assign out_ch.slot_active = out_active;
  assign out_ch.radius_disp = out_radius;

  `RZRT_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "request accepted but still ready")
  `RZRT_ASSERT_NOW(a_idx_in_range, st == ST_SLOT_A || st == ST_SLOT_B, 32'(idx) < SETPOINTS, "slot counter out of range")
  `RZRT_ASSERT_NEXT(a_main_cleared, st == ST_MAIN && req_q != REQ_UPDATE, main_delta[ax] == '0, "main delta not cleared on rezero")

endmodule
